FILE: rtl/time_bucket_assign_defines.svh
// assertion macros shared by the time bucket rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef TIME_BUCKET_ASSIGN_DEFINES_SVH
`define TIME_BUCKET_ASSIGN_DEFINES_SVH

// checked only out of reset
`define TBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define TBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: rtl/tba_pkg.sv
// types and constants of the time bucket block
// no dependencies
package tba_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_TIME  = 2'd0,
    CFG_BUCKET_WIDTH = 2'd1
  } tba_cfg_idx_e;

  // side information that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic invalid;
    logic neg;
    logic last;
  } tba_ctl_t;

endpackage

FILE: rtl/tba_prep.sv
// front stages: wrapped difference, width check, then dividend magnitude
// depends on tba_pkg
module tba_prep #(
  parameter int unsigned TW = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [tba_pkg::DATA_W-1:0] timestamp_i,
  input  logic                     last_i,
  input  logic [TW-1:0]            origin_i,
  input  logic [TW-1:0]            width_i,
  output tba_pkg::tba_ctl_t        ctl_o,
  output logic [TW-1:0]            mag_o
);
  import tba_pkg::*;

  tba_ctl_t      ctl_a_q, ctl_a_d;
  logic [TW-1:0] diff_q, diff_d;
  tba_ctl_t      ctl_b_q, ctl_b_d;
  logic [TW-1:0] mag_q, mag_d;

  always_comb begin
    ctl_a_d.valid   = valid_i;
    ctl_a_d.invalid = (width_i == '0) || width_i[TW-1];
    ctl_a_d.neg     = 1'b0;
    ctl_a_d.last    = last_i;
    diff_d          = timestamp_i[TW-1:0] - origin_i;
  end

  always_comb begin
    ctl_b_d     = ctl_a_q;
    ctl_b_d.neg = diff_q[TW-1];
    mag_d       = diff_q[TW-1] ? (~diff_q + TW'(1)) : diff_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_a_d;
      ctl_b_q <= ctl_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      mag_q  <= mag_d;
    end
  end

  assign ctl_o = ctl_b_q;
  assign mag_o = mag_q;

endmodule

FILE: rtl/tba_div_stage.sv
// one restoring division step: one quotient bit per stage
// depends on tba_pkg and the assertion macro header
`include "time_bucket_assign_defines.svh"

module tba_div_stage #(
  parameter int unsigned TW = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [TW-1:0]     div_i,
  input  tba_pkg::tba_ctl_t ctl_i,
  input  logic [TW-1:0]     rem_i,
  input  logic [TW-1:0]     quo_i,
  output tba_pkg::tba_ctl_t ctl_o,
  output logic [TW-1:0]     rem_o,
  output logic [TW-1:0]     quo_o
);
  import tba_pkg::*;

  tba_ctl_t      ctl_q;
  logic [TW-1:0] rem_q, rem_d;
  logic [TW-1:0] quo_q, quo_d;
  logic [TW:0]   trial;
  logic [TW:0]   sub;
  logic          ge;

  always_comb begin
    trial = {rem_i, quo_i[TW-1]};
    sub   = trial - {1'b0, div_i};
    ge    = ~sub[TW];
    rem_d = ge ? sub[TW-1:0] : trial[TW-1:0];
    quo_d = {quo_i[TW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

  // partial remainder stays below a valid divisor
  `TBA_ASSERT(a_rem_below_div, ctl_q.valid && !ctl_q.invalid |-> rem_q < div_i, "remainder not below divisor")

endmodule

FILE: rtl/tba_out.sv
// floor correction, sign extension and output register with skid entry
// depends on tba_pkg and the assertion macro header
`include "time_bucket_assign_defines.svh"

module tba_out #(
  parameter int unsigned TW = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tba_pkg::tba_ctl_t          ctl_i,
  input  logic [TW-1:0]              rem_i,
  input  logic [TW-1:0]              quo_i,
  output logic                       en_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tba_pkg::DATA_W-1:0] bucket_number_o,
  output logic                       status_o,
  output logic                       last_out_o
);
  import tba_pkg::*;

  tba_ctl_t          fin_ctl_q;
  logic [DATA_W-1:0] fin_res_q, fin_res_d;
  logic [TW-1:0]     fixed;
  logic              sk_v_q;
  logic [DATA_W-1:0] sk_res_q;
  logic              sk_status_q;
  logic              sk_last_q;
  logic              sk_fill;

  // negative dividend: ceil of magnitude, then negate
  always_comb begin
    fixed = ctl_i.neg ? (~quo_i + TW'(rem_i == '0)) : quo_i;
    if (ctl_i.invalid) begin
      fin_res_d = '0;
    end else begin
      fin_res_d = DATA_W'($signed(fixed));
    end
  end

  assign en_o    = ~sk_v_q;
  assign sk_fill = ~sk_v_q & fin_ctl_q.valid & ~out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_ctl_q <= '0;
      sk_v_q    <= 1'b0;
    end else begin
      if (en_o) begin
        fin_ctl_q <= ctl_i;
      end
      if (sk_fill) begin
        sk_v_q <= 1'b1;
      end else if (sk_v_q && out_ready_i) begin
        sk_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      fin_res_q <= fin_res_d;
    end
    if (sk_fill) begin
      sk_res_q    <= fin_res_q;
      sk_status_q <= fin_ctl_q.invalid;
      sk_last_q   <= fin_ctl_q.last;
    end
  end

  assign out_valid_o     = sk_v_q | fin_ctl_q.valid;
  assign bucket_number_o = sk_v_q ? sk_res_q : fin_res_q;
  assign status_o        = sk_v_q ? sk_status_q : fin_ctl_q.invalid;
  assign last_out_o      = sk_v_q ? sk_last_q : fin_ctl_q.last;

  `TBA_ASSERT(a_invalid_zero, out_valid_o && status_o |-> bucket_number_o == '0, "invalid width with nonzero bucket")
  `TBA_ASSERT(a_skid_freeze, sk_v_q |=> $stable(fin_ctl_q) && $stable(fin_res_q), "pipeline moved while skid full")
  `TBA_ASSERT(a_skid_cause, $rose(sk_v_q) |-> $past(fin_ctl_q.valid && !out_ready_i), "skid filled without stall")
  `TBA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result offered during reset")

endmodule

FILE: rtl/time_bucket_assign.sv
// Time bucket assignment: bucket_number = floor((timestamp - origin_time) / bucket_width),
// with the difference wrapping at TIME_WIDTH bits and a width of zero or below reported
// by status = 1 and bucket 0. One item is taken per clock while results are taken; the
// restoring divider resolves one quotient bit per pipeline stage, behind two front stages
// and ahead of one output stage. A result left waiting moves into a skid entry, so one
// more item is still taken behind it. Configuration writes are always ready; the user
// must keep configuration writes to an idle block, which the block itself does not enforce.
// depends on tba_pkg, tba_prep, tba_div_stage, tba_out
module time_bucket_assign #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tba_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tba_pkg::DATA_W-1:0]    timestamp_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tba_pkg::DATA_W-1:0]    bucket_number_o,
  output logic                          status_o,
  output logic                          last_out_o
);
  import tba_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;

  logic [TW-1:0] origin_q;
  logic [TW-1:0] width_q;
  logic          en;

  tba_ctl_t      ctl [0:TW];
  logic [TW-1:0] rem [0:TW];
  logic [TW-1:0] quo [0:TW];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      width_q  <= TW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ORIGIN_TIME:  origin_q <= cfg_data_i[TW-1:0];
        CFG_BUCKET_WIDTH: width_q  <= cfg_data_i[TW-1:0];
        default:          ;
      endcase
    end
  end

  tba_prep #(
    .TW (TW)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .timestamp_i (timestamp_i),
    .last_i      (last_in_i),
    .origin_i    (origin_q),
    .width_i     (width_q),
    .ctl_o       (ctl[0]),
    .mag_o       (quo[0])
  );

  assign rem[0] = '0;

  for (genvar g = 0; g < TW; g++) begin : g_div
    tba_div_stage #(
      .TW (TW)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .div_i  (width_q),
      .ctl_i  (ctl[g]),
      .rem_i  (rem[g]),
      .quo_i  (quo[g]),
      .ctl_o  (ctl[g+1]),
      .rem_o  (rem[g+1]),
      .quo_o  (quo[g+1])
    );
  end

  tba_out #(
    .TW (TW)
  ) u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl[TW]),
    .rem_i           (rem[TW]),
    .quo_i           (quo[TW]),
    .en_o            (en),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bucket_number_o (bucket_number_o),
    .status_o        (status_o),
    .last_out_o      (last_out_o)
  );

endmodule

FILE: test/bucket_checker.sv
// checker for the time bucket block: watches the register, input and result channels,
// predicts each bucket number from its own copy of the registers and compares in order
// depends on tba_pkg
`timescale 1ns / 100ps

module bucket_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [tba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tba_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [tba_pkg::DATA_W-1:0]    timestamp_i,
  input  logic                          last_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [tba_pkg::DATA_W-1:0]    bucket_number_i,
  input  logic                          status_i,
  input  logic                          last_out_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import tba_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] ts;
    logic [DATA_W-1:0] bucket;
    logic              status;
    logic              last;
  } bucket_result_t;

  bucket_result_t    bucket_expected_q[$];
  logic [DATA_W-1:0] origin_reg;
  logic [DATA_W-1:0] width_reg;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic bucket_result_t floor_bucket(input logic [DATA_W-1:0] ts,
                                                  input logic              lst,
                                                  input logic [DATA_W-1:0] org,
                                                  input logic [DATA_W-1:0] wid);
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] quo;
    bucket_result_t    r;
    r.ts     = ts;
    r.last   = lst;
    r.status = 1'b0;
    r.bucket = '0;
    if (wid == '0 || wid[DATA_W-1]) begin
      r.status = 1'b1;
    end else begin
      diff = ts - org;
      if (!diff[DATA_W-1]) begin
        r.bucket = diff / wid;
      end else begin
        // round the magnitude up, so the negated bucket rounds toward negative infinity
        mag = -diff;
        quo = mag / wid;
        if ((mag % wid) != '0) quo = quo + 1'b1;
        r.bucket = -quo;
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bucket_result_t exp_r;
    if (!rst_ni) begin
      origin_reg = '0;
      width_reg  = 64'd1;
      bucket_expected_q.delete();
      pending_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ORIGIN_TIME:  origin_reg = cfg_data_i;
          CFG_BUCKET_WIDTH: width_reg  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (bucket_expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result: bucket %h status %b last %b",
                                 bucket_number_i, status_i, last_out_i));
        end else begin
          exp_r = bucket_expected_q.pop_front();
          if (bucket_number_i !== exp_r.bucket || status_i !== exp_r.status ||
              last_out_i !== exp_r.last) begin
            note_failure($sformatf(
              "mismatch ts %h: expected bucket %h status %b last %b, got %h %b %b",
              exp_r.ts, exp_r.bucket, exp_r.status, exp_r.last,
              bucket_number_i, status_i, last_out_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        bucket_expected_q.push_back(floor_bucket(timestamp_i, last_in_i, origin_reg,
                                                 width_reg));
      end
      pending_o = bucket_expected_q.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// top of the time bucket testbench: clock, reset, register writes and timestamp stimulus
// with random idling; depends on tba_pkg, time_bucket_assign and bucket_checker
`timescale 1ns / 100ps

module tb_top;
  import tba_pkg::*;

  localparam int unsigned           LATENCY      = 64 + 3;
  localparam int unsigned           CYCLE_LIMIT  = 1000000;
  localparam int unsigned           RAND_PHASES  = 19;
  localparam int unsigned           PHASE_ITEMS  = 100;
  localparam int unsigned           QUIET_PHASES = 3;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_SPARE = 2'd3;
  localparam logic [DATA_W-1:0]     T_MIN = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0]     T_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [DATA_W-1:0]     T_NEG1 = 64'hffff_ffff_ffff_ffff;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b1;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [DATA_W-1:0]    timestamp_i = '0;
  logic                 last_in_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [DATA_W-1:0]    bucket_number_o;
  logic                 status_o;
  logic                 last_out_o;

  int                   fail_count;
  int                   pending;
  int                   cycle_count = 0;
  int                   stall_left = 0;
  bit                   quiet = 1'b0;
  logic [DATA_W-1:0]    cur_origin = '0;
  logic [DATA_W-1:0]    cur_width = 64'd1;

  time_bucket_assign u_top (.*);

  bucket_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .timestamp_i    (timestamp_i),
    .last_in_i      (last_in_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bucket_number_i(bucket_number_o),
    .status_i       (status_o),
    .last_out_i     (last_out_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i = 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left  = $urandom_range(1, 17) - 1;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == CFG_ORIGIN_TIME) cur_origin = data;
    if (idx == CFG_BUCKET_WIDTH) cur_width = data;
  endtask

  task automatic send_ts(input logic [DATA_W-1:0] ts, input logic lst);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    timestamp_i = ts;
    last_in_i   = lst;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [DATA_W-1:0] org;
    logic [DATA_W-1:0] wid;
    logic [DATA_W-1:0] ts;
    logic [DATA_W-1:0] k;
    // reset in force before the first rising edge
    #0.5 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset registers: origin zero, unit width
    send_ts('0, 1'b0);
    send_ts(T_MAX, 1'b1);
    send_ts(T_MIN, 1'b0);
    send_ts(T_NEG1, 1'b0);

    // power of two width around zero
    drain();
    cfg_write(CFG_BUCKET_WIDTH, 64'd8);
    send_ts(T_NEG1, 1'b0);
    send_ts(-64'd8, 1'b0);
    send_ts(-64'd9, 1'b0);
    send_ts(64'd7, 1'b1);
    send_ts(64'd8, 1'b0);

    // wrapped difference
    drain();
    cfg_write(CFG_ORIGIN_TIME, T_MAX);
    cfg_write(CFG_BUCKET_WIDTH, 64'd3);
    send_ts(T_MIN, 1'b0);
    send_ts(T_NEG1, 1'b1);
    send_ts(T_MAX, 1'b0);

    // invalid widths
    drain();
    cfg_write(CFG_BUCKET_WIDTH, '0);
    send_ts(64'd5, 1'b1);
    drain();
    cfg_write(CFG_BUCKET_WIDTH, T_NEG1);
    send_ts(T_MIN, 1'b0);
    drain();
    cfg_write(CFG_BUCKET_WIDTH, T_MIN);
    send_ts(T_MAX, 1'b1);

    // widest width from the lowest origin
    drain();
    cfg_write(CFG_ORIGIN_TIME, T_MIN);
    cfg_write(CFG_BUCKET_WIDTH, T_MAX);
    send_ts(T_MAX, 1'b0);
    send_ts(T_MIN, 1'b1);
    send_ts(T_NEG1, 1'b0);

    // unused register index is ignored
    drain();
    cfg_write(CFG_IDX_SPARE, rand64());
    send_ts(64'd12345, 1'b1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      quiet = (p >= RAND_PHASES - QUIET_PHASES);
      case ($urandom_range(0, 4))
        0: org = '0;
        1: org = T_MIN;
        2: org = T_MAX;
        3: org = rand64();
        default: begin
          org = 64'($urandom_range(0, 2000));
          org = org - 64'd1000;
        end
      endcase
      case ($urandom_range(0, 9))
        0: wid = 64'd1;
        1, 9: wid = 64'd1 << $urandom_range(1, 62);
        2: wid = 64'($urandom_range(2, 100));
        3: wid = rand64() >> 1;
        4: wid = T_MAX;
        5: wid = '0;
        6: wid = rand64() | T_MIN;
        7: wid = T_MIN;
        default: wid = 64'($urandom_range(2, 100000));
      endcase
      cfg_write(CFG_ORIGIN_TIME, org);
      cfg_write(CFG_BUCKET_WIDTH, wid);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) drain();
        case ($urandom_range(0, 3))
          0: ts = rand64();
          1: begin
            // near a bucket boundary
            k  = 64'($urandom_range(0, 40));
            k  = k - 64'd20;
            ts = cur_origin + k * cur_width + 64'($urandom_range(0, 2)) - 64'd1;
          end
          2: ts = cur_origin + 64'($urandom_range(0, 200)) - 64'd100;
          default: begin
            case ($urandom_range(0, 3))
              0: ts = T_MIN;
              1: ts = T_MAX;
              2: ts = '0;
              default: ts = T_NEG1;
            endcase
          end
        endcase
        send_ts(ts, 1'($urandom_range(0, 1)));
      end
    end

    drain();
    repeat (LATENCY + 10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
